FILE: src/sar_pkg.sv
// Shared types, constants and helper functions for the swept box refit block.
// Used by every module of the block but sar_ram; depends on nothing.
package sar_pkg;

  // Vertex store geometry
  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int IDX_W        = 10;
  localparam int COORD_W      = 32;
  localparam int PAD_W        = 31;
  localparam int POS_W        = 3 * COORD_W;

  // Request commands
  typedef enum logic [1:0] {
    CMD_WR_PREV = 2'd0,
    CMD_WR_CUR  = 2'd1,
    CMD_REFIT   = 2'd2,
    CMD_BEGIN   = 2'd3
  } cmd_t;

  // Primitive kinds; any other code is a triangle
  localparam logic [1:0] PRIM_POINT = 2'd0;
  localparam logic [1:0] PRIM_EDGE  = 2'd1;

  // Result box kinds
  localparam logic BOX_PRIM   = 1'b0;
  localparam logic BOX_OBJECT = 1'b1;

  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] vertex_index;
    logic [IDX_W-1:0] second_index;
    logic [IDX_W-1:0] third_index;
    logic [1:0]       prim_kind;
    coord_t           coord_x;
    coord_t           coord_y;
    coord_t           coord_z;
    logic             last_primitive;
  } req_t;

  typedef struct packed {
    logic   box_kind;
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
    logic   run_end;
  } rsp_t;

  // Tag that travels alongside a store read
  typedef struct packed {
    logic valid;
    logic seed;
    logic first;
    logic last;
    logic zero;
    logic last_prim;
  } rd_tag_t;

  // Finished unpadded box, or seed position, handed to the merge stage
  typedef struct packed {
    logic valid;
    logic seed;
    logic last_prim;
    vec_t lo;
    vec_t hi;
  } sweep_t;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] i);
    logic [31:0] w;
    w = 32'(i);
    return w[ADDR_W-1:0];
  endfunction

  function automatic logic in_range(input logic [IDX_W-1:0] i);
    return 32'(i) < 32'(MAX_VERTICES);
  endfunction

  function automatic vec_t vec_min(input vec_t a, input vec_t b);
    vec_t r;
    r.x = (a.x < b.x) ? a.x : b.x;
    r.y = (a.y < b.y) ? a.y : b.y;
    r.z = (a.z < b.z) ? a.z : b.z;
    return r;
  endfunction

  function automatic vec_t vec_max(input vec_t a, input vec_t b);
    vec_t r;
    r.x = (a.x > b.x) ? a.x : b.x;
    r.y = (a.y > b.y) ? a.y : b.y;
    r.z = (a.z > b.z) ? a.z : b.z;
    return r;
  endfunction

  // Clamp a 33-bit two's complement sum back into coordinate range
  function automatic coord_t clamp33(input logic [COORD_W:0] s);
    if (s[COORD_W] && !s[COORD_W-1]) begin
      return COORD_MIN;
    end else if (!s[COORD_W] && s[COORD_W-1]) begin
      return COORD_MAX;
    end
    return s[COORD_W-1:0];
  endfunction

  function automatic coord_t sub_sat(input coord_t v, input logic [PAD_W-1:0] p);
    logic [COORD_W:0] s;
    s = {v[COORD_W-1], v} - {2'b00, p};
    return clamp33(s);
  endfunction

  function automatic coord_t add_sat(input coord_t v, input logic [PAD_W-1:0] p);
    logic [COORD_W:0] s;
    s = {v[COORD_W-1], v} + {2'b00, p};
    return clamp33(s);
  endfunction

  function automatic vec_t vec_sub_sat(input vec_t v, input logic [PAD_W-1:0] p);
    vec_t r;
    r.x = sub_sat(v.x, p);
    r.y = sub_sat(v.y, p);
    r.z = sub_sat(v.z, p);
    return r;
  endfunction

  function automatic vec_t vec_add_sat(input vec_t v, input logic [PAD_W-1:0] p);
    vec_t r;
    r.x = add_sat(v.x, p);
    r.y = add_sat(v.y, p);
    r.z = add_sat(v.z, p);
    return r;
  endfunction

  function automatic rsp_t make_rsp(input logic kind, input vec_t lo, input vec_t hi,
                                    input logic run_end);
    rsp_t r;
    r.box_kind = kind;
    r.min_x    = lo.x;
    r.min_y    = lo.y;
    r.min_z    = lo.z;
    r.max_x    = hi.x;
    r.max_y    = hi.y;
    r.max_z    = hi.z;
    r.run_end  = run_end;
    return r;
  endfunction

endpackage

FILE: src/sar_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Self-contained; no package needed.
module sar_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read data; hold it while no read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/sar_issue.sv
// Issue stage: holds one request and drives the vertex store ports, one
// vertex a cycle while the merge stage does not hold the pipeline. Depends on sar_pkg.
module sar_issue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sar_pkg::req_t                 in_data,
  input  logic                          adv,
  output logic                          prev_we,
  output logic                          cur_we,
  output logic [sar_pkg::ADDR_W-1:0]    waddr,
  output sar_pkg::vec_t                 wdata,
  output logic                          re,
  output logic [sar_pkg::ADDR_W-1:0]    raddr,
  output sar_pkg::rd_tag_t              tag
);
  import sar_pkg::*;

  logic                 iss_valid;
  req_t                 iss;
  logic [1:0]           step;
  logic [1:0]           last_step;
  logic                 iss_final;
  logic                 accept;
  logic                 fire;
  logic [IDX_W-1:0]     sel_idx;
  rd_tag_t              tag_next;

  // Index of the last vertex step for the held request
  always_comb begin
    last_step = 2'd0;
    if (iss.cmd == CMD_REFIT) begin
      unique case (iss.prim_kind)
        PRIM_POINT: last_step = 2'd0;
        PRIM_EDGE:  last_step = 2'd1;
        default:    last_step = 2'd2;
      endcase
    end
  end

  assign iss_final = (step == last_step);
  assign in_stall  = !adv || (iss_valid && !iss_final);
  assign accept    = in_valid && !in_stall;
  assign fire      = iss_valid && adv;

  // Advance the step counter, or take the next request
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_valid <= 1'b0;
      step      <= 2'd0;
    end else if (adv) begin
      if (accept) begin
        iss_valid <= 1'b1;
        step      <= 2'd0;
      end else if (iss_valid && !iss_final) begin
        step <= step + 2'd1;
      end else begin
        iss_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      iss <= in_data;
    end
  end

  // Pick the vertex of this step; the seed reads vertex 0
  always_comb begin
    if (iss.cmd == CMD_BEGIN) begin
      sel_idx = '0;
    end else begin
      unique case (step)
        2'd1:    sel_idx = iss.second_index;
        2'd2:    sel_idx = iss.third_index;
        default: sel_idx = iss.vertex_index;
      endcase
    end
  end

  // Store ports
  assign prev_we = fire && (iss.cmd == CMD_WR_PREV) && in_range(iss.vertex_index);
  assign cur_we  = fire && (iss.cmd == CMD_WR_CUR) && in_range(iss.vertex_index);
  assign waddr   = to_addr(iss.vertex_index);
  assign wdata   = '{x: iss.coord_x, y: iss.coord_y, z: iss.coord_z};
  assign re      = fire && ((iss.cmd == CMD_REFIT) || (iss.cmd == CMD_BEGIN));
  assign raddr   = to_addr(sel_idx);

  // Tag that lines up with the registered read data
  always_comb begin
    tag_next.valid     = re;
    tag_next.seed      = (iss.cmd == CMD_BEGIN);
    tag_next.first     = (step == 2'd0);
    tag_next.last      = iss_final;
    tag_next.zero      = !in_range(sel_idx);
    tag_next.last_prim = iss.last_primitive;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else if (adv) begin
      tag <= tag_next;
    end
  end

endmodule

FILE: src/sar_accum.sv
// Sweep accumulator: folds the previous and current positions of each
// vertex read into a running min/max box. Depends on sar_pkg.
module sar_accum (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  sar_pkg::rd_tag_t  tag,
  input  sar_pkg::vec_t     prev_q,
  input  sar_pkg::vec_t     cur_q,
  output sar_pkg::sweep_t   sw
);
  import sar_pkg::*;

  vec_t acc_lo;
  vec_t acc_hi;
  vec_t p;
  vec_t c;
  vec_t pair_lo;
  vec_t pair_hi;
  vec_t lo_next;
  vec_t hi_next;

  // Drop the read data for an index beyond the store
  assign p = tag.zero ? '0 : prev_q;
  assign c = tag.zero ? '0 : cur_q;

  // Widen by both time steps, restart on the first vertex
  always_comb begin
    pair_lo = vec_min(p, c);
    pair_hi = vec_max(p, c);
    if (tag.first) begin
      lo_next = pair_lo;
      hi_next = pair_hi;
    end else begin
      lo_next = vec_min(pair_lo, acc_lo);
      hi_next = vec_max(pair_hi, acc_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tag.valid) begin
      acc_lo <= lo_next;
      acc_hi <= hi_next;
    end
  end

  // Hand the finished box, or the seed position, to the merge stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sw.valid <= 1'b0;
    end else if (adv) begin
      sw.valid <= tag.valid && (tag.seed || tag.last);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sw.seed      <= tag.seed;
      sw.last_prim <= tag.last_prim;
      sw.lo        <= tag.seed ? c : lo_next;
      sw.hi        <= tag.seed ? c : hi_next;
    end
  end

endmodule

FILE: src/sar_merge.sv
// Merge stage: pads the primitive box, keeps the object box and queues the
// results in a two-deep output register. Depends on sar_pkg.
module sar_merge (
  input  logic                         clk,
  input  logic                         rst,
  input  sar_pkg::sweep_t              sw,
  input  logic [sar_pkg::PAD_W-1:0]    pad,
  output logic                         adv,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sar_pkg::rsp_t                out_data
);
  import sar_pkg::*;

  vec_t obj_lo;
  vec_t obj_hi;
  vec_t plo;
  vec_t phi;
  vec_t mlo;
  vec_t mhi;
  logic sec_valid;
  rsp_t sec_q;
  logic out_free;
  logic fire;
  logic prim_fire;
  logic out_take;

  // Pad with saturation, then merge into the object box
  assign plo = vec_sub_sat(sw.lo, pad);
  assign phi = vec_add_sat(sw.hi, pad);
  assign mlo = vec_min(obj_lo, plo);
  assign mhi = vec_max(obj_hi, phi);

  // The output slot is free when empty or drained with nothing queued behind
  assign out_take  = out_valid && !out_stall;
  assign out_free  = !out_valid || (out_take && !sec_valid);
  assign fire      = sw.valid && (sw.seed || out_free);
  assign prim_fire = fire && !sw.seed;
  assign adv       = !sw.valid || fire;

  // Output and queue occupancy, object box
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sec_valid <= 1'b0;
      obj_lo    <= '0;
      obj_hi    <= '0;
    end else begin
      if (prim_fire) begin
        out_valid <= 1'b1;
        sec_valid <= sw.last_prim;
        obj_lo    <= mlo;
        obj_hi    <= mhi;
      end else if (out_take) begin
        out_valid <= sec_valid;
        sec_valid <= 1'b0;
      end
      if (fire && sw.seed) begin
        obj_lo <= sw.lo;
        obj_hi <= sw.hi;
      end
    end
  end

  // Result payloads
  always_ff @(posedge clk) begin
    if (prim_fire) begin
      out_data <= make_rsp(BOX_PRIM, plo, phi, !sw.last_prim);
      sec_q    <= make_rsp(BOX_OBJECT, mlo, mhi, 1'b1);
    end else if (out_take) begin
      out_data <= sec_q;
    end
  end

endmodule

FILE: src/swept_aabb_refit.sv
// Top level of the swept box refit block: issue stage, previous and current
// vertex stores, sweep accumulator and merge stage. Depends on sar_pkg.
//
// Vertex writes, object begins and point refits take one step each at the
// issue stage, an edge refit two and a triangle refit three: each step
// issues one access to the single-read-port previous and current position
// stores, which set the rate. A request enters while the previous one makes
// its last store access, so a new request is taken every cycle that the
// issue stage frees. A refit returns its padded swept box, and when marked
// last the merged object box in the next result; the final vertex read passes
// the store, accumulator and merge registers first. The stores need no clearing
// after reset. A stalled output holds the whole pipeline.
module swept_aabb_refit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  sar_pkg::req_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sar_pkg::rsp_t                out_data,
  input  logic                         cfg_write,
  input  logic [sar_pkg::PAD_W-1:0]    cfg_data
);
  import sar_pkg::*;

  logic [PAD_W-1:0]  pad_amount;
  logic              adv;
  logic              prev_we;
  logic              cur_we;
  logic [ADDR_W-1:0] waddr;
  vec_t              wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  rd_tag_t           tag;
  vec_t              prev_q;
  vec_t              cur_q;
  sweep_t            sw;

  // Padding register
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_amount <= '0;
    end else if (cfg_write) begin
      pad_amount <= cfg_data;
    end
  end

  sar_issue u_issue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (adv),
    .prev_we  (prev_we),
    .cur_we   (cur_we),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (re),
    .raddr    (raddr),
    .tag      (tag)
  );

  sar_ram #(
    .WIDTH (POS_W),
    .DEPTH (MAX_VERTICES)
  ) u_prev_store (
    .clk   (clk),
    .we    (prev_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (prev_q)
  );

  sar_ram #(
    .WIDTH (POS_W),
    .DEPTH (MAX_VERTICES)
  ) u_cur_store (
    .clk   (clk),
    .we    (cur_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (cur_q)
  );

  sar_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .tag    (tag),
    .prev_q (prev_q),
    .cur_q  (cur_q),
    .sw     (sw)
  );

  sar_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .sw        (sw),
    .pad       (pad_amount),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: src/sar_check.sv
// Port-level checker for the swept box refit block, bound to its top level.
// Depends on sar_pkg.
module sar_check (
  input  logic          clk,
  input  logic          rst,
  input  logic          out_valid,
  input  logic          out_stall,
  input  sar_pkg::rsp_t out_data
);
  import sar_pkg::*;

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // A primitive box that does not end its run is followed at once by the object box
  a_object_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_data.run_end) |=>
      (out_valid && (out_data.box_kind == BOX_OBJECT)))
    else $error("object box missing after primitive box");

  // Every box keeps min at or below max
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (($signed(out_data.min_x) <= $signed(out_data.max_x)) &&
                   ($signed(out_data.min_y) <= $signed(out_data.max_y)) &&
                   ($signed(out_data.min_z) <= $signed(out_data.max_z))))
    else $error("box with min above max");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind swept_aabb_refit sar_check u_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: test/tb_swept_aabb_refit.sv
// Self-checking bench for swept_aabb_refit: vertex loads, point, edge and triangle refits
// and merged object boxes under several padding settings, with random source gaps and
// sink stalls. Depends on sar_pkg and the swept_aabb_refit top level.
module tb_swept_aabb_refit;
  import sar_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 230;

  localparam logic [1:0] PRIM_TRIANGLE = 2'd2;
  localparam logic [1:0] PRIM_ODD      = 2'd3;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_BUSY, SINK_PERIODIC} sink_mode_e;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  req_t             in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  rsp_t             out_data;
  logic             cfg_write = 1'b0;
  logic [PAD_W-1:0] cfg_data  = '0;

  swept_aabb_refit uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  // Predicted block state
  coord_t           prev_pos [MAX_VERTICES][3];
  coord_t           cur_pos  [MAX_VERTICES][3];
  coord_t           obj_lo [3] = '{default: '0};
  coord_t           obj_hi [3] = '{default: '0};
  logic [PAD_W-1:0] pad_q16 = '0;
  rsp_t             boxes_due [$];
  rsp_t             box_want;

  // Stimulus state, tracked at the time requests are queued
  req_t             request_queue [$];
  bit               prev_loaded [MAX_VERTICES];
  bit               cur_loaded  [MAX_VERTICES];
  bit               listed      [MAX_VERTICES];
  int               usable_verts [$];

  bit               request_taken = 1'b0;
  int               burst_left = 1;
  int               gap_left = 0;
  sink_mode_e       sink_mode = SINK_OPEN;
  int               sink_run = 0;
  int               error_count = 0;
  int               cycle_count = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic coord_t clip_q16(input longint v);
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    return v[COORD_W-1:0];
  endfunction

  function automatic rsp_t pack_box(input logic kind, input coord_t lo [3],
                                    input coord_t hi [3], input logic end_flag);
    rsp_t b;
    b.box_kind = kind;
    b.min_x    = lo[0];
    b.min_y    = lo[1];
    b.min_z    = lo[2];
    b.max_x    = hi[0];
    b.max_y    = hi[1];
    b.max_z    = hi[2];
    b.run_end  = end_flag;
    return b;
  endfunction

  // Apply one accepted request to the predicted state and queue its boxes
  function automatic void sweep_request(input req_t r);
    logic [IDX_W-1:0] corner [3];
    coord_t           lo [3];
    coord_t           hi [3];
    int               nverts;
    corner[0] = r.vertex_index;
    corner[1] = r.second_index;
    corner[2] = r.third_index;
    case (r.cmd)
      CMD_WR_PREV: begin
        prev_pos[r.vertex_index] = '{r.coord_x, r.coord_y, r.coord_z};
      end
      CMD_WR_CUR: begin
        cur_pos[r.vertex_index] = '{r.coord_x, r.coord_y, r.coord_z};
      end
      CMD_BEGIN: begin
        obj_lo = cur_pos[0];
        obj_hi = cur_pos[0];
      end
      default: begin
        nverts = (r.prim_kind == PRIM_POINT) ? 1 : (r.prim_kind == PRIM_EDGE) ? 2 : 3;
        lo = prev_pos[corner[0]];
        hi = lo;
        // sweep both time steps of every vertex
        for (int v = 0; v < nverts; v++) begin
          for (int a = 0; a < 3; a++) begin
            if (prev_pos[corner[v]][a] < lo[a]) lo[a] = prev_pos[corner[v]][a];
            if (prev_pos[corner[v]][a] > hi[a]) hi[a] = prev_pos[corner[v]][a];
            if (cur_pos[corner[v]][a] < lo[a]) lo[a] = cur_pos[corner[v]][a];
            if (cur_pos[corner[v]][a] > hi[a]) hi[a] = cur_pos[corner[v]][a];
          end
        end
        // pad with saturation, then grow the object box
        for (int a = 0; a < 3; a++) begin
          lo[a] = clip_q16(longint'(lo[a]) - longint'(pad_q16));
          hi[a] = clip_q16(longint'(hi[a]) + longint'(pad_q16));
          if (lo[a] < obj_lo[a]) obj_lo[a] = lo[a];
          if (hi[a] > obj_hi[a]) obj_hi[a] = hi[a];
        end
        boxes_due.push_back(pack_box(BOX_PRIM, lo, hi, !r.last_primitive));
        if (r.last_primitive) boxes_due.push_back(pack_box(BOX_OBJECT, obj_lo, obj_hi, 1'b1));
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // Coordinates: extremes, full range and values near the origin
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 7))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2, 3, 4: return coord_t'($urandom);
      default: return coord_t'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  function automatic req_t make_req(input cmd_t c, input logic [1:0] kind,
                                    input logic last_flag);
    req_t r;
    r.cmd            = c;
    r.vertex_index   = IDX_W'($urandom_range(0, MAX_VERTICES - 1));
    r.second_index   = IDX_W'($urandom_range(0, MAX_VERTICES - 1));
    r.third_index    = IDX_W'($urandom_range(0, MAX_VERTICES - 1));
    r.prim_kind      = kind;
    r.coord_x        = pick_coord();
    r.coord_y        = pick_coord();
    r.coord_z        = pick_coord();
    r.last_primitive = last_flag;
    return r;
  endfunction

  function automatic void queue_write(input cmd_t c, input int idx, input coord_t x,
                                      input coord_t y, input coord_t z);
    req_t r;
    r = make_req(c, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    r.vertex_index = IDX_W'(idx);
    r.coord_x      = x;
    r.coord_y      = y;
    r.coord_z      = z;
    request_queue.push_back(r);
    if (c == CMD_WR_PREV) prev_loaded[idx] = 1'b1;
    else cur_loaded[idx] = 1'b1;
    if (prev_loaded[idx] && cur_loaded[idx] && !listed[idx]) begin
      listed[idx] = 1'b1;
      usable_verts.push_back(idx);
    end
  endfunction

  function automatic void queue_refit(input logic [1:0] kind, input int a, input int b,
                                      input int c, input logic last_flag);
    req_t r;
    r = make_req(CMD_REFIT, kind, last_flag);
    r.vertex_index = IDX_W'(a);
    r.second_index = IDX_W'(b);
    r.third_index  = IDX_W'(c);
    request_queue.push_back(r);
  endfunction

  function automatic void queue_begin();
    request_queue.push_back(make_req(CMD_BEGIN, 2'($urandom_range(0, 3)),
                                     1'($urandom_range(0, 1))));
  endfunction

  function automatic int any_ready();
    return usable_verts[$urandom_range(0, usable_verts.size() - 1)];
  endfunction

  // Unused corners of points and edges take any index: they are never read
  function automatic void queue_random_refit(input logic last_flag);
    logic [1:0] kind;
    int         b;
    int         c;
    kind = 2'($urandom_range(0, 3));
    b = (kind == PRIM_POINT) ? int'($urandom_range(0, MAX_VERTICES - 1)) : any_ready();
    c = (kind == PRIM_POINT || kind == PRIM_EDGE) ?
        int'($urandom_range(0, MAX_VERTICES - 1)) : any_ready();
    queue_refit(kind, any_ready(), b, c, last_flag);
  endfunction

  // Mostly whole objects (begin, refits, last), with loose writes and stray refits
  function automatic void queue_random_phase(input int count);
    int idx;
    int refits;
    while (request_queue.size() < count) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          idx = $urandom_range(0, MAX_VERTICES - 1);
          queue_write(CMD_WR_PREV, idx, pick_coord(), pick_coord(), pick_coord());
          queue_write(CMD_WR_CUR, idx, pick_coord(), pick_coord(), pick_coord());
        end
        8: queue_random_refit(1'($urandom_range(0, 1)));
        9: begin
          queue_write($urandom_range(0, 1) ? CMD_WR_CUR : CMD_WR_PREV,
                      $urandom_range(0, MAX_VERTICES - 1),
                      pick_coord(), pick_coord(), pick_coord());
        end
        default: begin
          if ($urandom_range(0, 4) != 0) queue_begin();
          refits = $urandom_range(1, 6);
          for (int k = 1; k <= refits; k++) begin
            if ($urandom_range(0, 5) == 0)
              queue_write(CMD_WR_CUR, any_ready(), pick_coord(), pick_coord(), pick_coord());
            queue_random_refit(k == refits);
          end
        end
      endcase
    end
  endfunction

  task automatic write_pad(input logic [PAD_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    pad_q16 = value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait for every request to go in and every box to come out, then let writes settle
  task automatic drain();
    do @(posedge clk);
    while (request_queue.size() != 0 || in_valid || boxes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Request source: bursts of random length with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !request_taken) begin
      // hold the stalled request
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (request_queue.size() == 0) begin
      in_valid <= 1'b0;
    end else begin
      in_data  <= request_queue.pop_front();
      in_valid <= 1'b1;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
    request_taken = 1'b0;
  end

  // Result sink: stall pattern switches mode after runs of random length
  always @(negedge clk) begin
    if (sink_run == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_run  = $urandom_range(10, 120);
    end
    sink_run--;
    case (sink_mode)
      SINK_OPEN: out_stall <= 1'b0;
      SINK_COIN: out_stall <= ($urandom_range(0, 1) == 0);
      SINK_BUSY: out_stall <= ($urandom_range(0, 4) != 0);
      default:   out_stall <= (sink_run % 4 == 0);
    endcase
  end

  // Monitor: predict on accepted requests, check accepted boxes in order
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sweep_request(in_data);
      request_taken = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      if (boxes_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected box, expected none, actual %h", $time, out_data);
      end else begin
        box_want = boxes_due.pop_front();
        check_field("box_kind", box_want.box_kind, out_data.box_kind);
        check_field("min_x", box_want.min_x, out_data.min_x);
        check_field("min_y", box_want.min_y, out_data.min_y);
        check_field("min_z", box_want.min_z, out_data.min_z);
        check_field("max_x", box_want.max_x, out_data.max_x);
        check_field("max_y", box_want.max_y, out_data.max_y);
        check_field("max_z", box_want.max_z, out_data.max_z);
        check_field("run_end", box_want.run_end, out_data.run_end);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [PAD_W-1:0] pad_plan [6];
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    pad_plan = '{31'h7FFF_FFFF, 31'd1, PAD_W'($urandom_range(0, 32'h0010_0000)),
                 PAD_W'($urandom), 31'h0001_0000, 31'd0};

    // Directed: extreme coordinates and indices, every kind, no padding
    write_pad('0);
    queue_write(CMD_WR_PREV, 0, COORD_MIN, COORD_MAX, 0);
    queue_write(CMD_WR_CUR, 0, COORD_MAX, COORD_MIN, -1);
    queue_write(CMD_WR_PREV, MAX_VERTICES - 1, 1, -1, 32'sh0001_0000);
    queue_write(CMD_WR_CUR, MAX_VERTICES - 1, -32'sh0001_0000, 32'sh5555_5555,
                32'shAAAA_AAAA);
    queue_write(CMD_WR_PREV, 512, pick_coord(), pick_coord(), pick_coord());
    queue_write(CMD_WR_CUR, 512, pick_coord(), pick_coord(), pick_coord());
    // refits before any begin merge into the all-zero object box
    queue_refit(PRIM_POINT, MAX_VERTICES - 1, 0, 0, 1'b1);
    queue_refit(PRIM_EDGE, 0, MAX_VERTICES - 1, 512, 1'b1);
    queue_begin();
    queue_refit(PRIM_TRIANGLE, 0, 512, MAX_VERTICES - 1, 1'b0);
    // undefined kind behaves as a triangle
    queue_refit(PRIM_ODD, MAX_VERTICES - 1, 0, 512, 1'b1);
    queue_refit(PRIM_EDGE, 512, 512, 0, 1'b0);
    queue_refit(PRIM_POINT, 0, MAX_VERTICES - 1, MAX_VERTICES - 1, 1'b1);
    drain();

    foreach (pad_plan[p]) begin
      write_pad(pad_plan[p]);
      if (p == 0) begin
        // full-scale padding on extreme vertices saturates both ends
        queue_refit(PRIM_POINT, 0, 512, 512, 1'b1);
        queue_refit(PRIM_TRIANGLE, 0, 512, MAX_VERTICES - 1, 1'b1);
        queue_begin();
        queue_refit(PRIM_EDGE, MAX_VERTICES - 1, 0, 512, 1'b1);
      end
      queue_random_phase(PHASE_ITEMS);
      drain();
    end

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
